### sv/bvmw_pkg.sv
// Shared types, constants and helpers for the banked video memory window.
`default_nettype none
package bvmw_pkg;

  // Default sizes handed to the top-level parameters
  localparam int unsigned VIDEO_BANK_BYTES_DEF = 8192;
  localparam int unsigned AUX_BYTES_DEF        = 2048;

  // Graphics ROM page size is fixed: page number lands on address bits 18:12
  localparam int unsigned ROM_PAGE_BYTES = 4096;
  localparam int unsigned ROM_OFS_W      = 12;

  // Transaction kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_FRAME = 2'd3;

  // Bus map
  localparam logic [15:0] WINDOW_MASK   = 16'he000;
  localparam logic [15:0] WINDOW_BASE   = 16'hc000;
  localparam logic [15:0] AUX_WR_LIMIT  = 16'hc800;
  localparam logic [15:0] ROM_RD_LIMIT  = 16'hd000;
  localparam logic [15:0] AUX_RD_LIMIT  = 16'hd800;
  localparam logic [15:0] PORT_MODE     = 16'hdfff;
  localparam logic [15:0] PORT_RELOAD   = 16'hf00d;
  localparam logic [15:0] PORT_FRM_ACK  = 16'hf00e;
  localparam logic [15:0] PORT_TMR_ACK  = 16'hf00f;
  localparam logic [15:0] PORT_BANK     = 16'hf480;
  localparam logic [15:0] PORT_FLIP     = 16'hf4c0;
  localparam logic [15:0] PORT_ROM_PAGE = 16'hf500;

  // Window modes
  localparam logic [7:0] MODE_VIDEO    = 8'd0;
  localparam logic [7:0] MODE_AUX      = 8'd2;
  localparam logic [7:0] MODE_BANK_SEL = 8'd3;

  // Data masks
  localparam logic [7:0] BANK_SEL_MASK = 8'hfe;
  localparam logic [7:0] PAGE_MASK     = 8'h7f;

  localparam logic [3:0] BANK_REG_RESET = 4'd4;

  // Register state seen by the sequencer
  typedef struct packed {
    logic [7:0] window_mode;
    logic       video_bank;
    logic       write_enable;
    logic [3:0] bank_reg;
    logic [7:0] rom_page;
    logic       frame_irq;
    logic       timer_irq;
    logic       flip;
    logic       aux0_lsb;   // copy of aux entry 0, bit 0
    logic [7:0] aux1;       // copy of aux entry 1
  } ctrl_state_t;

  // Memory actions decoded from one transaction
  typedef struct packed {
    logic video_we;
    logic aux_we;
    logic read_video;
    logic read_aux;
    logic rom_read;
    logic fill_start;
  } act_t;

  // Wrap a window offset into a store of the given size by compare and subtract;
  // the quotient never exceeds seven for the supported sizes.
  function automatic logic [12:0] wrap_offset(input logic [12:0] value,
                                              input int unsigned size);
    logic [12:0] res;
    res = value;
    for (int unsigned k = 1; k < 8; k++) begin
      if (32'(value) >= k * size) begin
        res = 13'(32'(value) - k * size);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### sv/banked_video_memory_window.sv
// Top level: sequencer around the video and auxiliary RAMs.
`default_nettype none
// After reset the block sweeps both RAMs to zero, one entry per cycle, with
// in_ready low. A transaction's RAM read is issued on the accept edge and the
// result register loads from it once the output is free; in_ready returns on
// that same edge unless a fill follows. A write with bit 6 set to port 0xf480
// adds a fill sweep of VIDEO_BANK_BYTES bytes, one byte per cycle through the
// single RAM write port, after its result is loaded. One result is returned
// per transaction, in order.
module banked_video_memory_window #(
  parameter int unsigned VIDEO_BANK_BYTES = bvmw_pkg::VIDEO_BANK_BYTES_DEF,
  parameter int unsigned AUX_BYTES        = bvmw_pkg::AUX_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  kind,
  input  wire  [15:0] address,
  input  wire  [7:0]  data,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  read_data,
  output logic        rom_read,
  output logic [18:0] rom_address,
  output logic [3:0]  program_bank,
  output logic        frame_irq,
  output logic        timer_irq,
  output logic        flip_screen
);
  import bvmw_pkg::*;

  localparam int unsigned VA_W = $clog2(2 * VIDEO_BANK_BYTES);
  localparam int unsigned AA_W = $clog2(AUX_BYTES);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;
  localparam logic [1:0] ST_FILL  = 2'd3;

  logic [1:0]      state;
  logic [1:0]      state_next;
  logic [VA_W-1:0] sweep;
  logic            sweep_last;
  logic            accept;
  logic            out_free;
  ctrl_state_t     st;
  act_t            act;

  logic            rd_video_q;
  logic            rd_aux_q;
  logic            rom_q;
  logic [18:0]     rom_addr_q;
  logic            fill_q;
  logic            fill_bank;
  logic [7:0]      fill_value;
  logic [VA_W-1:0] rd_vaddr_q;
  logic [AA_W-1:0] rd_aaddr_q;

  logic [12:0]     video_ofs;
  logic [12:0]     aux_ofs;
  logic [VA_W-1:0] video_idx;
  logic [AA_W-1:0] aux_idx;
  logic [VA_W-1:0] fill_addr;

  logic            vid_we;
  logic [VA_W-1:0] vid_waddr;
  logic [7:0]      vid_wdata;
  logic [VA_W-1:0] vid_raddr;
  logic [7:0]      vid_rdata;
  logic            aux_we;
  logic [AA_W-1:0] aux_waddr;
  logic [7:0]      aux_wdata;
  logic [AA_W-1:0] aux_raddr;
  logic [7:0]      aux_rdata;
  logic            clear_we;
  logic            fill_we;
  logic            acc_we;

  assign in_ready = state == ST_IDLE;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  bvmw_ctrl #(
    .AUX_BYTES(AUX_BYTES)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .kind    (kind),
    .address (address),
    .data    (data),
    .st      (st),
    .act     (act)
  );

  // Map window offsets into the stores
  assign video_ofs = wrap_offset(address[12:0], VIDEO_BANK_BYTES);
  assign aux_ofs   = wrap_offset({2'b00, address[10:0]}, AUX_BYTES);
  assign video_idx = st.video_bank ? VA_W'(VIDEO_BANK_BYTES) + VA_W'(video_ofs)
                                   : VA_W'(video_ofs);
  assign aux_idx   = AA_W'(aux_ofs);
  assign fill_addr = fill_bank ? VA_W'(VIDEO_BANK_BYTES) + sweep : sweep;

  // Hold the read address while the result waits so the read data stays put
  assign vid_raddr = in_ready ? video_idx : rd_vaddr_q;
  assign aux_raddr = in_ready ? aux_idx : rd_aaddr_q;

  assign sweep_last = (state == ST_CLEAR) ? (sweep == VA_W'(2 * VIDEO_BANK_BYTES - 1))
                                          : (sweep == VA_W'(VIDEO_BANK_BYTES - 1));

  // Select the write source for each RAM
  assign clear_we = state == ST_CLEAR;
  assign fill_we  = state == ST_FILL;
  assign acc_we   = accept && (act.video_we || act.aux_we);

  always_comb begin
    vid_we    = 1'b0;
    vid_waddr = video_idx;
    vid_wdata = data;
    aux_we    = 1'b0;
    aux_waddr = aux_idx;
    aux_wdata = data;
    if (clear_we) begin
      vid_we    = 1'b1;
      vid_waddr = sweep;
      vid_wdata = 8'd0;
      aux_we    = 32'(sweep) < 32'(AUX_BYTES);
      aux_waddr = sweep[AA_W-1:0];
      aux_wdata = 8'd0;
    end else if (fill_we) begin
      vid_we    = 1'b1;
      vid_waddr = fill_addr;
      vid_wdata = fill_value;
    end else if (accept) begin
      vid_we = act.video_we;
      aux_we = act.aux_we;
    end
  end

  bvmw_ram #(
    .WIDTH(8),
    .DEPTH(2 * VIDEO_BANK_BYTES)
  ) u_video_ram (
    .clk   (clk),
    .we    (vid_we),
    .waddr (vid_waddr),
    .wdata (vid_wdata),
    .raddr (vid_raddr),
    .rdata (vid_rdata)
  );

  bvmw_ram #(
    .WIDTH(8),
    .DEPTH(AUX_BYTES)
  ) u_aux_ram (
    .clk   (clk),
    .we    (aux_we),
    .waddr (aux_waddr),
    .wdata (aux_wdata),
    .raddr (aux_raddr),
    .rdata (aux_rdata)
  );

  // Sequence: clear, accept, finish, optional fill
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (sweep_last) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = fill_q ? ST_FILL : ST_IDLE;
      ST_FILL:  if (sweep_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR || state == ST_FILL) begin
        sweep <= sweep_last ? '0 : sweep + VA_W'(1);
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the accepted transaction's read selection and fill request
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_video_q <= act.read_video;
      rd_aux_q   <= act.read_aux;
      rom_q      <= act.rom_read;
      rom_addr_q <= act.rom_read ? {st.rom_page[6:0], address[ROM_OFS_W-1:0]} : 19'd0;
      fill_q     <= act.fill_start;
      fill_bank  <= st.aux0_lsb;
      fill_value <= st.aux1;
      rd_vaddr_q <= video_idx;
      rd_aaddr_q <= aux_idx;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      read_data    <= rd_video_q ? vid_rdata : (rd_aux_q ? aux_rdata : 8'd0);
      rom_read     <= rom_q;
      rom_address  <= rom_addr_q;
      program_bank <= st.bank_reg;
      frame_irq    <= st.frame_irq;
      timer_irq    <= st.timer_irq;
      flip_screen  <= st.flip;
    end
  end

  // Checks
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DONE) else $error("accepted transaction did not finish");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({clear_we, fill_we, acc_we})) else $error("RAM write sources collide");

  a_load_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE) else $error("result loaded outside finish");

  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_CLEAR || state == ST_FILL) && sweep_last) |=> state == ST_IDLE)
    else $error("sweep did not return to idle");

  a_read_excl: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> $onehot0({rd_video_q, rd_aux_q, rom_q}))
    else $error("conflicting read sources");

endmodule
`default_nettype wire

### sv/bvmw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none
module bvmw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/bvmw_ctrl.sv
// Control registers, tick timer, interrupt flags and transaction decode.
`default_nettype none
module bvmw_ctrl #(
  parameter int unsigned AUX_BYTES = bvmw_pkg::AUX_BYTES_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   accept,
  input  wire [1:0]             kind,
  input  wire [15:0]            address,
  input  wire [7:0]             data,
  output bvmw_pkg::ctrl_state_t st,
  output bvmw_pkg::act_t        act
);
  import bvmw_pkg::*;

  logic [8:0]  tick_count;
  logic [7:0]  tick_reload;
  logic        in_window;
  logic        is_port;
  logic        bank_sel;
  logic [12:0] aux_idx;

  assign in_window = (address & WINDOW_MASK) == WINDOW_BASE;
  assign is_port   = (address == PORT_MODE) || (address == PORT_RELOAD) ||
                     (address == PORT_FRM_ACK) || (address == PORT_TMR_ACK) ||
                     (address == PORT_BANK) || (address == PORT_FLIP) ||
                     (address == PORT_ROM_PAGE);
  assign bank_sel  = (st.window_mode == MODE_BANK_SEL) && (address == WINDOW_BASE) &&
                     ((data & BANK_SEL_MASK) == 8'd0);
  assign aux_idx   = wrap_offset({2'b00, address[10:0]}, AUX_BYTES);

  // Decode memory actions for the transaction on the input port
  always_comb begin
    act = '0;
    if (kind == KIND_WRITE) begin
      if (in_window && !is_port && !bank_sel && st.write_enable) begin
        act.video_we = st.window_mode == MODE_VIDEO;
        act.aux_we   = (st.window_mode == MODE_AUX) && (address < AUX_WR_LIMIT);
      end
      act.fill_start = (address == PORT_BANK) && data[6];
    end else if (kind == KIND_READ && in_window) begin
      if (st.rom_page != 8'd0 && address < ROM_RD_LIMIT) begin
        act.rom_read = 1'b1;
      end else if (st.window_mode == MODE_VIDEO) begin
        act.read_video = 1'b1;
      end else if (st.window_mode == MODE_AUX && address < AUX_RD_LIMIT) begin
        act.read_aux = 1'b1;
      end
    end
  end

  // Apply register updates for each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '{window_mode: 8'd0, video_bank: 1'b0, write_enable: 1'b0,
                       bank_reg: BANK_REG_RESET, rom_page: 8'd0, frame_irq: 1'b0,
                       timer_irq: 1'b0, flip: 1'b0, aux0_lsb: 1'b0, aux1: 8'd0};
      tick_count  <= '0;
      tick_reload <= '0;
    end else if (accept) begin
      case (kind)
        KIND_WRITE: begin
          case (address)
            PORT_MODE:     st.window_mode <= data;
            PORT_RELOAD:   tick_reload <= data;
            PORT_FRM_ACK:  st.frame_irq <= 1'b0;
            PORT_TMR_ACK:  st.timer_irq <= 1'b0;
            PORT_BANK: begin
              st.write_enable <= data[7];
              st.bank_reg     <= data[3:0];
            end
            PORT_FLIP:     st.flip <= data[5];
            PORT_ROM_PAGE: st.rom_page <= data;
            default: begin
              if (in_window && bank_sel) begin
                st.video_bank <= data[0];
              end
              // Track aux entries 0 and 1 for the bank fill
              if (act.aux_we && aux_idx == 13'd0) begin
                st.aux0_lsb <= data[0];
              end
              if (act.aux_we && aux_idx == 13'd1) begin
                st.aux1 <= data;
              end
            end
          endcase
        end
        KIND_TICK: begin
          if (tick_count <= 9'd1) begin
            st.timer_irq <= 1'b1;
            tick_count   <= {1'b0, tick_reload};
          end else begin
            tick_count <= tick_count - 9'd1;
          end
        end
        KIND_FRAME: st.frame_irq <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### bench/banked_video_memory_window_tb.sv
// Testbench for the banked video memory window: directed table, then random bus traffic.
`timescale 1ns / 1ps
module banked_video_memory_window_tb;
  import bvmw_pkg::*;

  localparam int unsigned VB           = VIDEO_BANK_BYTES_DEF;
  localparam int unsigned AUXB         = AUX_BYTES_DEF;
  localparam int          RANDOM_ITEMS = 940;
  localparam int          PHASE_LEN    = RANDOM_ITEMS / 4;
  localparam int          FILL_CAP     = 24;
  localparam int          DRAIN_CYCLES = VIDEO_BANK_BYTES_DEF + 64;
  localparam int          MAX_CYCLES   = 2_000_000;
  localparam int          N_ROWS       = 26;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rom_read;
    logic [18:0] rom_address;
    logic [3:0]  program_bank;
    logic        frame_irq;
    logic        timer_irq;
    logic        flip_screen;
  } bus_result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic        typed;
    bus_result_t result;
  } bus_row_t;

  localparam bus_result_t NOT_TYPED    = '0;
  localparam bus_result_t RESET_RESULT =
    '{8'h00, 1'b0, 19'h0, BANK_REG_RESET, 1'b0, 1'b0, 1'b0};
  localparam bus_result_t BANK15_RESULT =
    '{8'h00, 1'b0, 19'h0, 4'hf, 1'b0, 1'b0, 1'b0};

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [15:0] address;
  logic [7:0]  data;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  read_data;
  logic        rom_read;
  logic [18:0] rom_address;
  logic [3:0]  program_bank;
  logic        frame_irq;
  logic        timer_irq;
  logic        flip_screen;

  // Predicted block state
  bit [7:0]    vid_ram [2*VB];
  bit [7:0]    aux_ram [AUXB];
  logic [7:0]  win_mode;
  logic        vid_bank;
  logic        wr_en;
  logic [3:0]  prog_bank;
  logic [7:0]  gfx_page;
  logic [8:0]  tick_left;
  logic [7:0]  tick_reload_val;
  logic        frame_pend;
  logic        timer_pend;
  logic        flip_bit;

  bus_result_t expected_results[$];
  bus_result_t oldest;
  int          fail_count;
  int          cycle_count;
  int          fills_issued;
  int          idle_pct;
  int          stall_pct;

  // Directed transactions: reset values, extremes, every port but the frame acknowledge, and special cases
  bus_row_t directed_rows [N_ROWS] = '{
    '{KIND_READ,  16'hc000,      8'h00, 1'b1, RESET_RESULT},
    '{KIND_READ,  16'hffff,      8'hff, 1'b1, RESET_RESULT},
    '{KIND_WRITE, PORT_BANK,     8'h8f, 1'b1, BANK15_RESULT},
    '{KIND_WRITE, 16'hc000,      8'hff, 1'b0, NOT_TYPED},
    '{KIND_WRITE, 16'hdffe,      8'h5a, 1'b0, NOT_TYPED},
    '{KIND_WRITE, PORT_MODE,     8'h03, 1'b0, NOT_TYPED},
    '{KIND_WRITE, 16'hc000,      8'h01, 1'b0, NOT_TYPED},
    '{KIND_WRITE, 16'hc000,      8'h02, 1'b0, NOT_TYPED},
    '{KIND_WRITE, PORT_MODE,     8'h02, 1'b0, NOT_TYPED},
    '{KIND_WRITE, 16'hc000,      8'h01, 1'b0, NOT_TYPED},
    '{KIND_WRITE, 16'hc001,      8'ha5, 1'b0, NOT_TYPED},
    '{KIND_WRITE, 16'hc7ff,      8'h3c, 1'b0, NOT_TYPED},
    '{KIND_WRITE, 16'hc800,      8'h11, 1'b0, NOT_TYPED},
    '{KIND_READ,  16'hd7ff,      8'h00, 1'b0, NOT_TYPED},
    '{KIND_READ,  16'hd800,      8'h00, 1'b0, NOT_TYPED},
    '{KIND_WRITE, PORT_BANK,     8'hc4, 1'b0, NOT_TYPED},
    '{KIND_WRITE, PORT_MODE,     8'h00, 1'b0, NOT_TYPED},
    '{KIND_READ,  16'hc123,      8'h00, 1'b0, NOT_TYPED},
    '{KIND_WRITE, PORT_ROM_PAGE, 8'hff, 1'b0, NOT_TYPED},
    '{KIND_READ,  16'hcfff,      8'h00, 1'b0, NOT_TYPED},
    '{KIND_WRITE, PORT_FLIP,     8'h20, 1'b0, NOT_TYPED},
    '{KIND_WRITE, PORT_RELOAD,   8'h02, 1'b0, NOT_TYPED},
    '{KIND_TICK,  16'h0000,      8'h00, 1'b0, NOT_TYPED},
    '{KIND_TICK,  16'hffff,      8'hff, 1'b0, NOT_TYPED},
    '{KIND_FRAME, 16'h0000,      8'h00, 1'b0, NOT_TYPED},
    '{KIND_WRITE, PORT_TMR_ACK,  8'h00, 1'b0, NOT_TYPED}
  };

  banked_video_memory_window dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .address      (address),
    .data         (data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .rom_read     (rom_read),
    .rom_address  (rom_address),
    .program_bank (program_bank),
    .frame_irq    (frame_irq),
    .timer_irq    (timer_irq),
    .flip_screen  (flip_screen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned vid_slot(input logic [15:0] a);
    return int'(vid_bank) * VB + (int'(a[12:0]) % VB);
  endfunction

  function automatic int unsigned aux_slot(input logic [15:0] a);
    return int'(a[10:0]) % AUXB;
  endfunction

  // Advance the predicted state by one transaction and form its result
  task automatic predict_bus(input logic [1:0] k, input logic [15:0] a,
                             input logic [7:0] d, output bus_result_t r);
    int unsigned base;
    r = '0;
    case (k)
      KIND_READ: begin
        if ((a & WINDOW_MASK) == WINDOW_BASE) begin
          if (gfx_page != 8'd0 && a < ROM_RD_LIMIT) begin
            r.rom_read    = 1'b1;
            r.rom_address = {gfx_page[6:0], a[11:0]};
          end else if (win_mode == MODE_VIDEO) begin
            r.read_data = vid_ram[vid_slot(a)];
          end else if (win_mode == MODE_AUX && a < AUX_RD_LIMIT) begin
            r.read_data = aux_ram[aux_slot(a)];
          end
        end
      end
      KIND_WRITE: begin
        case (a)
          PORT_MODE:     win_mode = d;
          PORT_RELOAD:   tick_reload_val = d;
          PORT_FRM_ACK:  frame_pend = 1'b0;
          PORT_TMR_ACK:  timer_pend = 1'b0;
          PORT_FLIP:     flip_bit = d[5];
          PORT_ROM_PAGE: gfx_page = d;
          PORT_BANK: begin
            // fill the bank named by aux entry 0 with aux entry 1
            if (d[6]) begin
              base = aux_ram[0][0] ? VB : 0;
              for (int i = 0; i < VB; i++) vid_ram[base + i] = aux_ram[1];
            end
            wr_en     = d[7];
            prog_bank = d[3:0];
          end
          default: begin
            if ((a & WINDOW_MASK) == WINDOW_BASE) begin
              if (win_mode == MODE_BANK_SEL && a == WINDOW_BASE &&
                  (d & BANK_SEL_MASK) == 8'd0) begin
                vid_bank = d[0];
              end else if (wr_en) begin
                if (win_mode == MODE_VIDEO) vid_ram[vid_slot(a)] = d;
                else if (win_mode == MODE_AUX && a < AUX_WR_LIMIT) aux_ram[aux_slot(a)] = d;
              end
            end
          end
        endcase
      end
      KIND_TICK: begin
        if (tick_left <= 9'd1) begin
          timer_pend = 1'b1;
          tick_left  = {1'b0, tick_reload_val};
        end else begin
          tick_left = tick_left - 9'd1;
        end
      end
      default: frame_pend = 1'b1;
    endcase
    r.program_bank = prog_bank;
    r.frame_irq    = frame_pend;
    r.timer_irq    = timer_pend;
    r.flip_screen  = flip_bit;
  endtask

  // Hold one transaction on the input until accepted, then record its expectation
  task automatic send_txn(input logic [1:0] k, input logic [15:0] a, input logic [7:0] d,
                          input logic typed, input bus_result_t typed_res);
    bus_result_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    address  <= a;
    data     <= d;
    do @(posedge clk); while (!in_ready);
    predict_bus(k, a, d, predicted);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // Draw one random transaction, mostly well-formed window and port traffic
  task automatic pick_item(output logic [1:0] k, output logic [15:0] a,
                           output logic [7:0] d);
    int unsigned sel;
    logic [15:0] win_addr;
    sel = $urandom_range(0, 99);
    k   = KIND_WRITE;
    d   = 8'($urandom);
    if ($urandom_range(0, 4) == 0) win_addr = WINDOW_BASE + 16'($urandom_range(0, 3));
    else win_addr = WINDOW_BASE | 16'($urandom_range(0, 16'h1fff));
    a = win_addr;
    if (sel < 28) begin
      k = KIND_READ;
    end else if (sel < 52) begin
      if ($urandom_range(0, 9) == 0) begin
        a = WINDOW_BASE;
        d = 8'($urandom_range(0, 1));
      end
    end else if (sel < 60) begin
      a = PORT_MODE;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: d = MODE_VIDEO;
        4, 5, 6:    d = MODE_AUX;
        7, 8:       d = MODE_BANK_SEL;
        default:    d = 8'($urandom);
      endcase
    end else if (sel < 66) begin
      a    = PORT_BANK;
      d[7] = ($urandom_range(0, 4) != 0);
      d[6] = (fills_issued < FILL_CAP && $urandom_range(0, 7) == 0);
    end else if (sel < 70) begin
      a = PORT_ROM_PAGE;
      if ($urandom_range(0, 1) == 0) d = 8'd0;
    end else if (sel < 73) begin
      a = PORT_FLIP;
    end else if (sel < 76) begin
      a = PORT_RELOAD;
      if ($urandom_range(0, 3) != 0) d = 8'($urandom_range(0, 5));
    end else if (sel < 80) begin
      a = $urandom_range(0, 1) ? PORT_FRM_ACK : PORT_TMR_ACK;
    end else if (sel < 89) begin
      k = KIND_TICK;
      a = 16'($urandom);
    end else if (sel < 93) begin
      k = KIND_FRAME;
      a = 16'($urandom);
    end else begin
      k = 2'($urandom_range(0, 3));
      a = 16'($urandom);
    end
    if (k == KIND_WRITE && a == PORT_BANK && d[6]) fills_issued++;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Drive the receiver side, compare each result, and watch the cycle limit
  always @(posedge clk) begin
    cycle_count++;
    out_ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
    if (cycle_count >= MAX_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end else if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no pending transaction");
        fail_count++;
      end else begin
        oldest = expected_results.pop_front();
        check_field("read_data",    oldest.read_data,    read_data);
        check_field("rom_read",     oldest.rom_read,     rom_read);
        check_field("rom_address",  oldest.rom_address,  rom_address);
        check_field("program_bank", oldest.program_bank, program_bank);
        check_field("frame_irq",    oldest.frame_irq,    frame_irq);
        check_field("timer_irq",    oldest.timer_irq,    timer_irq);
        check_field("flip_screen",  oldest.flip_screen,  flip_screen);
      end
    end
  end

  initial begin : stimulus
    logic [1:0]  k;
    logic [15:0] a;
    logic [7:0]  d;
    rst             = 1'b1;
    in_valid        = 1'b0;
    kind            = KIND_READ;
    address         = 16'h0000;
    data            = 8'h00;
    out_ready       = 1'b0;
    fail_count      = 0;
    cycle_count     = 0;
    fills_issued    = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    win_mode        = 8'd0;
    vid_bank        = 1'b0;
    wr_en           = 1'b0;
    prog_bank       = BANK_REG_RESET;
    gfx_page        = 8'd0;
    tick_left       = 9'd0;
    tick_reload_val = 8'd0;
    frame_pend      = 1'b0;
    timer_pend      = 1'b0;
    flip_bit        = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table with no idling
    for (int r = 0; r < N_ROWS; r++) begin
      send_txn(directed_rows[r].kind, directed_rows[r].address, directed_rows[r].data,
               directed_rows[r].typed, directed_rows[r].result);
    end

    // Random traffic across the idling phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (n / PHASE_LEN)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 63; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      pick_item(k, a, d);
      send_txn(k, a, d, 1'b0, NOT_TYPED);
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then give a trailing fill time to finish
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
